@@ rtl/core/bpcr_pkg.sv @@
// Shared types and codes for the clock-replacement frame table.
`default_nettype none
package bpcr_pkg;

  // Command codes of an input item.
  typedef enum logic [2:0] {
    CMD_REQUEST  = 3'd0,
    CMD_UNPIN    = 3'd1,
    CMD_ALLOCATE = 3'd2,
    CMD_DISPOSE  = 3'd3,
    CMD_FLUSH    = 3'd4
  } cmd_t;

  // Status codes of a result item.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EXCEEDED   = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_NOT_PINNED = 3'd3,
    ST_PINNED     = 3'd4
  } status_t;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned FRAME_BITS  = 4;
  localparam int unsigned IN_FILE_BITS = 8;
  localparam int unsigned IN_PAGE_BITS = 20;
  localparam logic [7:0]  PIN_MAX     = 8'd255;

endpackage : bpcr_pkg
`default_nettype wire

@@ rtl/core/bpcr_front.sv @@
// Front end: accepts items, drops unknown commands, and queues the rest.
`default_nettype none
module bpcr_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [bpcr_pkg::CMD_BITS-1:0]   in_command,
  input  wire logic [bpcr_pkg::IN_FILE_BITS-1:0] in_file_id,
  input  wire logic [bpcr_pkg::IN_PAGE_BITS-1:0] in_page_no,
  input  wire logic                            in_mark_dirty,
  output logic                                 q_valid,
  input  wire logic                            q_take,
  output logic [bpcr_pkg::CMD_BITS-1:0]        q_command,
  output logic [bpcr_pkg::IN_FILE_BITS-1:0]    q_file_id,
  output logic [bpcr_pkg::IN_PAGE_BITS-1:0]    q_page_no,
  output logic                                 q_mark_dirty
);
  import bpcr_pkg::*;

  localparam int unsigned ENTRY_BITS = CMD_BITS + IN_FILE_BITS + IN_PAGE_BITS + 1;

  // Two-entry queue held in registers.
  logic [ENTRY_BITS-1:0] mem_r [2];
  logic                  wp_r, rp_r;
  logic [1:0]            cnt_r;
  logic                  known;
  logic                  push, pop;
  logic [ENTRY_BITS-1:0] head;

  // Commands above flush are dropped at the door.
  assign known    = (in_command <= CMD_BITS'(CMD_FLUSH));
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && known;
  assign pop      = q_valid && q_take;
  assign q_valid  = (cnt_r != 2'd0);
  assign head     = mem_r[rp_r];
  assign {q_command, q_file_id, q_page_no, q_mark_dirty} = head;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {in_command, in_file_id, in_page_no, in_mark_dirty};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule : bpcr_front
`default_nettype wire

@@ rtl/core/bpcr_back.sv @@
// Back end: frame table, tag search, clock sweep and flush scan.
`default_nettype none
module bpcr_back #(
  parameter int unsigned NUM_FRAMES   = 16,
  parameter int unsigned FILE_ID_BITS = 8,
  parameter int unsigned PAGE_BITS    = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  output logic                                   q_take,
  input  wire logic [bpcr_pkg::CMD_BITS-1:0]     q_command,
  input  wire logic [bpcr_pkg::IN_FILE_BITS-1:0] q_file_id,
  input  wire logic [bpcr_pkg::IN_PAGE_BITS-1:0] q_page_no,
  input  wire logic                              q_mark_dirty,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bpcr_pkg::STATUS_BITS-1:0]       out_status,
  output logic [bpcr_pkg::FRAME_BITS-1:0]        out_frame,
  output logic                                   out_fill_needed,
  output logic                                   out_writeback,
  output logic [bpcr_pkg::IN_FILE_BITS-1:0]      out_wb_file_id,
  output logic [bpcr_pkg::IN_PAGE_BITS-1:0]      out_wb_page_no,
  output logic                                   out_last
);
  import bpcr_pkg::*;

  localparam int unsigned IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned SW = $clog2(2 * NUM_FRAMES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_FRAMES - 1);
  localparam logic [SW-1:0] SWEEP_MAX = SW'(2 * NUM_FRAMES);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOKUP, S_DECIDE, S_SWEEP, S_FLUSH, S_EMIT
  } state_t;

  // Per-frame control bits and tags.
  logic [NUM_FRAMES-1:0]   valid_r, ref_r, dirty_r;
  logic [7:0]              pins_r [NUM_FRAMES];
  logic [FILE_ID_BITS-1:0] ftag_r [NUM_FRAMES];
  logic [PAGE_BITS-1:0]    ptag_r [NUM_FRAMES];
  logic [IW-1:0]           hand_r;

  state_t                  state_r;
  logic [CMD_BITS-1:0]     cmd_r;
  logic [FILE_ID_BITS-1:0] f_r;
  logic [PAGE_BITS-1:0]    p_r;
  logic                    md_r;
  logic                    hit_r;
  logic [IW-1:0]           hidx_r;
  logic [SW-1:0]           steps_r;
  logic [IW-1:0]           scan_r;

  // Result register.
  logic                    ov_r;
  logic [STATUS_BITS-1:0]  st_r;
  logic [FRAME_BITS-1:0]   fr_r;
  logic                    fill_r, wb_r, last_r;
  logic [IN_FILE_BITS-1:0] wf_r;
  logic [IN_PAGE_BITS-1:0] wpg_r;

  // Tag compare against all frames, lowest index wins.
  logic [NUM_FRAMES-1:0] match;
  logic                  hit;
  logic [IW-1:0]         hidx;
  always_comb begin
    hit  = 1'b0;
    hidx = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      match[i] = valid_r[i] && ftag_r[i] == f_r && ptag_r[i] == p_r;
    end
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit  = 1'b1;
        hidx = IW'(i);
      end
    end
  end

  logic [IW-1:0] nhand;
  assign nhand = (hand_r == LAST_IDX) ? '0 : hand_r + 1'b1;

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign q_take   = (state_r == S_IDLE);

  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_frame       = fr_r;
  assign out_fill_needed = fill_r;
  assign out_writeback   = wb_r;
  assign out_wb_file_id  = wf_r;
  assign out_wb_page_no  = wpg_r;
  assign out_last        = last_r;

  // Sequencer, frame table updates and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      ref_r       <= '0;
      dirty_r     <= '0;
      hand_r      <= LAST_IDX;
      ov_r        <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) pins_r[i] <= 8'd0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_command;
            f_r     <= q_file_id[FILE_ID_BITS-1:0];
            p_r     <= q_page_no[PAGE_BITS-1:0];
            md_r    <= q_mark_dirty;
            steps_r <= '0;
            scan_r  <= '0;
            state_r <= (q_command == CMD_BITS'(CMD_FLUSH)) ? S_FLUSH : S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          hit_r   <= hit;
          hidx_r  <= hidx;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            st_r   <= ST_OK;
            fr_r   <= '0;
            fill_r <= 1'b0;
            wb_r   <= 1'b0;
            wf_r   <= '0;
            wpg_r  <= '0;
            last_r <= 1'b1;
            state_r <= S_IDLE;
            case (cmd_r)
              CMD_BITS'(CMD_REQUEST): begin
                if (hit_r) begin
                  ref_r[hidx_r] <= 1'b1;
                  if (pins_r[hidx_r] != PIN_MAX) pins_r[hidx_r] <= pins_r[hidx_r] + 8'd1;
                  fr_r <= FRAME_BITS'(hidx_r);
                  ov_r <= 1'b1;
                end else begin
                  state_r <= S_SWEEP;
                end
              end
              CMD_BITS'(CMD_ALLOCATE): state_r <= S_SWEEP;
              CMD_BITS'(CMD_UNPIN): begin
                ov_r <= 1'b1;
                if (!hit_r) begin
                  st_r <= ST_NOT_FOUND;
                end else if (pins_r[hidx_r] == 8'd0) begin
                  st_r <= ST_NOT_PINNED;
                  fr_r <= FRAME_BITS'(hidx_r);
                end else begin
                  pins_r[hidx_r]  <= pins_r[hidx_r] - 8'd1;
                  dirty_r[hidx_r] <= dirty_r[hidx_r] | md_r;
                  fr_r <= FRAME_BITS'(hidx_r);
                end
              end
              default: begin
                // Dispose.
                ov_r <= 1'b1;
                if (hit_r) begin
                  valid_r[hidx_r] <= 1'b0;
                  ref_r[hidx_r]   <= 1'b0;
                  dirty_r[hidx_r] <= 1'b0;
                  pins_r[hidx_r]  <= 8'd0;
                  fr_r <= FRAME_BITS'(hidx_r);
                end
              end
            endcase
          end
        end
        S_SWEEP: begin
          // One hand step per cycle while the output is free; results wait for a free output.
          if (out_free) begin
            if (steps_r == SWEEP_MAX) begin
              ov_r    <= 1'b1;
              st_r    <= ST_EXCEEDED;
              fr_r    <= '0;
              fill_r  <= 1'b0;
              wb_r    <= 1'b0;
              wf_r    <= '0;
              wpg_r   <= '0;
              last_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              hand_r  <= nhand;
              steps_r <= steps_r + 1'b1;
              if (valid_r[nhand] && ref_r[nhand]) begin
                ref_r[nhand] <= 1'b0;
              end else if (!valid_r[nhand] || pins_r[nhand] == 8'd0) begin
                ov_r   <= 1'b1;
                st_r   <= ST_OK;
                fr_r   <= FRAME_BITS'(nhand);
                fill_r <= (cmd_r == CMD_BITS'(CMD_REQUEST));
                wb_r   <= valid_r[nhand] && dirty_r[nhand];
                wf_r   <= (valid_r[nhand] && dirty_r[nhand])
                          ? IN_FILE_BITS'(ftag_r[nhand]) : '0;
                wpg_r  <= (valid_r[nhand] && dirty_r[nhand])
                          ? IN_PAGE_BITS'(ptag_r[nhand]) : '0;
                last_r <= 1'b1;
                ftag_r[nhand]  <= f_r;
                ptag_r[nhand]  <= p_r;
                valid_r[nhand] <= 1'b1;
                ref_r[nhand]   <= 1'b1;
                dirty_r[nhand] <= 1'b0;
                pins_r[nhand]  <= 8'd1;
                state_r <= S_IDLE;
              end
            end
          end
        end
        S_FLUSH: begin
          // One frame per cycle while the output is free, from frame zero upward.
          if (out_free) begin
            fill_r <= 1'b0;
            if (valid_r[scan_r] && ftag_r[scan_r] == f_r) begin
              if (pins_r[scan_r] != 8'd0) begin
                ov_r    <= 1'b1;
                st_r    <= ST_PINNED;
                fr_r    <= FRAME_BITS'(scan_r);
                wb_r    <= 1'b0;
                wf_r    <= '0;
                wpg_r   <= '0;
                last_r  <= 1'b1;
                state_r <= S_IDLE;
              end else begin
                if (dirty_r[scan_r]) begin
                  ov_r   <= 1'b1;
                  st_r   <= ST_OK;
                  fr_r   <= FRAME_BITS'(scan_r);
                  wb_r   <= 1'b1;
                  wf_r   <= IN_FILE_BITS'(ftag_r[scan_r]);
                  wpg_r  <= IN_PAGE_BITS'(ptag_r[scan_r]);
                  last_r <= 1'b0;
                  dirty_r[scan_r] <= 1'b0;
                end
                valid_r[scan_r] <= 1'b0;
                scan_r <= scan_r + 1'b1;
                if (scan_r == LAST_IDX) state_r <= S_EMIT;
              end
            end else begin
              scan_r <= scan_r + 1'b1;
              if (scan_r == LAST_IDX) state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ov_r    <= 1'b1;
            st_r    <= ST_OK;
            fr_r    <= '0;
            fill_r  <= 1'b0;
            wb_r    <= 1'b0;
            wf_r    <= '0;
            wpg_r   <= '0;
            last_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule : bpcr_back
`default_nettype wire

@@ rtl/core/buffer_pool_clock_replacement.sv @@
// Top level of the clock-replacement frame table of a page buffer pool.
//
//  channel | direction | handshake           | fields
//  in_     | input     | in_valid / in_stall | command, file_id, page_no, mark_dirty
//  out_    | output    | out_valid/out_stall | status, frame, fill_needed, writeback,
//          |           |                     | wb_file_id, wb_page_no, last
//
// Request on a miss and allocate run the clock sweep, which advances the hand by
// one frame per cycle while the output is free.
// Flush scans one frame per cycle while the output is free.
// A two-item queue lets the front accept items while the back works.
// Synchronous reset clears all frame control bits and sets the hand to the last frame.
`default_nettype none
module buffer_pool_clock_replacement #(
  parameter int unsigned NUM_FRAMES   = 16,
  parameter int unsigned FILE_ID_BITS = 8,
  parameter int unsigned PAGE_BITS    = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bpcr_pkg::CMD_BITS-1:0]     in_command,
  input  wire logic [bpcr_pkg::IN_FILE_BITS-1:0] in_file_id,
  input  wire logic [bpcr_pkg::IN_PAGE_BITS-1:0] in_page_no,
  input  wire logic                              in_mark_dirty,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bpcr_pkg::STATUS_BITS-1:0]       out_status,
  output logic [bpcr_pkg::FRAME_BITS-1:0]        out_frame,
  output logic                                   out_fill_needed,
  output logic                                   out_writeback,
  output logic [bpcr_pkg::IN_FILE_BITS-1:0]      out_wb_file_id,
  output logic [bpcr_pkg::IN_PAGE_BITS-1:0]      out_wb_page_no,
  output logic                                   out_last
);
  import bpcr_pkg::*;

  logic                    q_valid, q_take, q_mark_dirty;
  logic [CMD_BITS-1:0]     q_command;
  logic [IN_FILE_BITS-1:0] q_file_id;
  logic [IN_PAGE_BITS-1:0] q_page_no;

  // Front end and item queue.
  bpcr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_file_id, .in_page_no,
    .in_mark_dirty, .q_valid, .q_take, .q_command, .q_file_id, .q_page_no,
    .q_mark_dirty
  );

  // Frame table engine.
  bpcr_back #(
    .NUM_FRAMES(NUM_FRAMES), .FILE_ID_BITS(FILE_ID_BITS), .PAGE_BITS(PAGE_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_command, .q_file_id, .q_page_no,
    .q_mark_dirty, .out_valid, .out_stall, .out_status, .out_frame,
    .out_fill_needed, .out_writeback, .out_wb_file_id, .out_wb_page_no, .out_last
  );

endmodule : buffer_pool_clock_replacement
`default_nettype wire

@@ rtl/core/bpcr_checker.sv @@
// Port checker for the frame table, bound to the top level.
`default_nettype none
module bpcr_port_props (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_status,
  input wire logic       out_fill_needed,
  input wire logic       out_writeback,
  input wire logic       out_last
);
  import bpcr_pkg::*;

  // A stalled result stays presented.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  // A write-back that is not the last item comes only from a flush with status ok.
  a_flush_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_writeback && out_status == STATUS_BITS'(ST_OK))
    else $error("bad intermediate item");

  // A fill is asked for only with status ok.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_needed |-> out_status == STATUS_BITS'(ST_OK))
    else $error("fill with error status");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

  // The input queue is empty and open right after reset.
  a_open: assert property (@(posedge clk)
    !rst_n |=> !in_stall) else $error("input stalled after reset");

endmodule : bpcr_port_props

bind buffer_pool_clock_replacement bpcr_port_props u_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_status,
  .out_fill_needed, .out_writeback, .out_last
);
`default_nettype wire

@@ dv/bpcr_checker.sv @@
// Checker for the clock-replacement frame table: predicts and compares result items.
`timescale 1ns / 100ps
module bpcr_checker #(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_stall,
  input  wire logic [bpcr_pkg::CMD_BITS-1:0]     in_command,
  input  wire logic [bpcr_pkg::IN_FILE_BITS-1:0] in_file_id,
  input  wire logic [bpcr_pkg::IN_PAGE_BITS-1:0] in_page_no,
  input  wire logic                              in_mark_dirty,
  input  wire logic                              out_valid,
  input  wire logic                              out_stall,
  input  wire logic [bpcr_pkg::STATUS_BITS-1:0]  out_status,
  input  wire logic [bpcr_pkg::FRAME_BITS-1:0]   out_frame,
  input  wire logic                              out_fill_needed,
  input  wire logic                              out_writeback,
  input  wire logic [bpcr_pkg::IN_FILE_BITS-1:0] out_wb_file_id,
  input  wire logic [bpcr_pkg::IN_PAGE_BITS-1:0] out_wb_page_no,
  input  wire logic                              out_last,
  output int                                     fail_count,
  output int                                     pending_results,
  output int                                     writebacks_seen,
  output int                                     exceeded_seen
);
  import bpcr_pkg::*;

  typedef struct packed {
    status_t                 status;
    logic [FRAME_BITS-1:0]   frame;
    logic                    fill;
    logic                    wb;
    logic [IN_FILE_BITS-1:0] wb_file;
    logic [IN_PAGE_BITS-1:0] wb_page;
    logic                    last;
  } frame_result_t;

  // Shadow copy of the frame table.
  logic                    tbl_valid [NUM_FRAMES];
  logic                    tbl_ref   [NUM_FRAMES];
  logic                    tbl_dirty [NUM_FRAMES];
  logic [7:0]              tbl_pins  [NUM_FRAMES];
  logic [IN_FILE_BITS-1:0] tbl_file  [NUM_FRAMES];
  logic [IN_PAGE_BITS-1:0] tbl_page  [NUM_FRAMES];
  int unsigned             hand;

  frame_result_t expected_results[$];

  function automatic void push_result(status_t st, int fr, logic fill, logic wb,
                                      logic [IN_FILE_BITS-1:0] wf,
                                      logic [IN_PAGE_BITS-1:0] wp, logic last);
    frame_result_t r;
    r.status  = st;
    r.frame   = fr[FRAME_BITS-1:0];
    r.fill    = fill;
    r.wb      = wb;
    r.wb_file = wf;
    r.wb_page = wp;
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  function automatic int find_page(logic [IN_FILE_BITS-1:0] f, logic [IN_PAGE_BITS-1:0] p);
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (tbl_valid[i] && tbl_file[i] == f && tbl_page[i] == p) return i;
    end
    return -1;
  endfunction

  function automatic void drop_frame(int i);
    tbl_valid[i] = 1'b0;
    tbl_ref[i]   = 1'b0;
    tbl_dirty[i] = 1'b0;
    tbl_pins[i]  = 8'd0;
  endfunction

  // Clock sweep over at most two turns; reports the evicted dirty page.
  function automatic int pick_victim(output logic wb, output logic [IN_FILE_BITS-1:0] wf,
                                     output logic [IN_PAGE_BITS-1:0] wp);
    int i;
    wb = 1'b0;
    wf = '0;
    wp = '0;
    for (int n = 0; n < 2 * NUM_FRAMES; n++) begin
      hand = (hand + 1) % NUM_FRAMES;
      i = hand;
      if (!tbl_valid[i]) begin
        drop_frame(i);
        return i;
      end
      if (tbl_ref[i]) begin
        tbl_ref[i] = 1'b0;
        continue;
      end
      if (tbl_pins[i] != 0) continue;
      if (tbl_dirty[i]) begin
        wb = 1'b1;
        wf = tbl_file[i];
        wp = tbl_page[i];
      end
      drop_frame(i);
      return i;
    end
    return -1;
  endfunction

  // Works out the result items of one accepted input item.
  function automatic void predict_frame_results(logic [CMD_BITS-1:0] cmd,
                                                logic [IN_FILE_BITS-1:0] f,
                                                logic [IN_PAGE_BITS-1:0] p, logic md);
    int i;
    logic wb;
    logic [IN_FILE_BITS-1:0] wf;
    logic [IN_PAGE_BITS-1:0] wp;
    case (cmd)
      CMD_REQUEST, CMD_ALLOCATE: begin
        i = (cmd == CMD_REQUEST) ? find_page(f, p) : -1;
        if (i >= 0) begin
          tbl_ref[i] = 1'b1;
          if (tbl_pins[i] != PIN_MAX) tbl_pins[i]++;
          push_result(ST_OK, i, 1'b0, 1'b0, '0, '0, 1'b1);
        end else begin
          i = pick_victim(wb, wf, wp);
          if (i < 0) begin
            push_result(ST_EXCEEDED, 0, 1'b0, 1'b0, '0, '0, 1'b1);
          end else begin
            tbl_file[i]  = f;
            tbl_page[i]  = p;
            tbl_valid[i] = 1'b1;
            tbl_ref[i]   = 1'b1;
            tbl_dirty[i] = 1'b0;
            tbl_pins[i]  = 8'd1;
            push_result(ST_OK, i, cmd == CMD_REQUEST, wb, wf, wp, 1'b1);
          end
        end
      end
      CMD_UNPIN: begin
        i = find_page(f, p);
        if (i < 0) begin
          push_result(ST_NOT_FOUND, 0, 1'b0, 1'b0, '0, '0, 1'b1);
        end else if (tbl_pins[i] == 0) begin
          push_result(ST_NOT_PINNED, i, 1'b0, 1'b0, '0, '0, 1'b1);
        end else begin
          tbl_pins[i]--;
          tbl_dirty[i] = tbl_dirty[i] | md;
          push_result(ST_OK, i, 1'b0, 1'b0, '0, '0, 1'b1);
        end
      end
      CMD_DISPOSE: begin
        i = find_page(f, p);
        if (i >= 0) drop_frame(i);
        push_result(ST_OK, (i >= 0) ? i : 0, 1'b0, 1'b0, '0, '0, 1'b1);
      end
      CMD_FLUSH: begin
        for (i = 0; i < NUM_FRAMES; i++) begin
          if (!tbl_valid[i] || tbl_file[i] != f) continue;
          if (tbl_pins[i] != 0) begin
            push_result(ST_PINNED, i, 1'b0, 1'b0, '0, '0, 1'b1);
            return;
          end
          if (tbl_dirty[i]) begin
            push_result(ST_OK, i, 1'b0, 1'b1, tbl_file[i], tbl_page[i], 1'b0);
            tbl_dirty[i] = 1'b0;
          end
          tbl_valid[i] = 1'b0;
        end
        push_result(ST_OK, 0, 1'b0, 1'b0, '0, '0, 1'b1);
      end
      default: ;  // unknown commands are ignored
    endcase
  endfunction

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        drop_frame(i);
        tbl_file[i] = '0;
        tbl_page[i] = '0;
      end
      hand = NUM_FRAMES - 1;
      expected_results.delete();
      fail_count = 0;
      writebacks_seen = 0;
      exceeded_seen = 0;
    end else begin
      if (in_valid && !in_stall)
        predict_frame_results(in_command, in_file_id, in_page_no, in_mark_dirty);
      if (out_valid && !out_stall) begin
        if (out_writeback) writebacks_seen++;
        if (out_status == ST_EXCEEDED) exceeded_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result item, status %0d frame %0d",
                     $realtime, out_status, out_frame);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_status != exp_r.status || out_frame != exp_r.frame ||
              out_fill_needed != exp_r.fill || out_writeback != exp_r.wb ||
              out_wb_file_id != exp_r.wb_file || out_wb_page_no != exp_r.wb_page ||
              out_last != exp_r.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result differs (status frame fill wb file page last)", $realtime);
              $display("  expected %0d %0d %0d %0d %0h %0h %0d", exp_r.status, exp_r.frame,
                       exp_r.fill, exp_r.wb, exp_r.wb_file, exp_r.wb_page, exp_r.last);
              $display("  actual   %0d %0d %0d %0d %0h %0h %0d", out_status, out_frame,
                       out_fill_needed, out_writeback, out_wb_file_id, out_wb_page_no,
                       out_last);
            end
          end
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

@@ dv/tb_buffer_pool_clock_replacement.sv @@
// Testbench top for the clock-replacement frame table: stimulus and verdict.
`timescale 1ns / 100ps
module tb_buffer_pool_clock_replacement;
  import bpcr_pkg::*;

  localparam int NUM_FRAMES = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 3 * NUM_FRAMES + 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_BITS-1:0] in_command;
  logic [IN_FILE_BITS-1:0] in_file_id;
  logic [IN_PAGE_BITS-1:0] in_page_no;
  logic in_mark_dirty;
  logic out_valid;
  logic out_stall;
  logic [STATUS_BITS-1:0] out_status;
  logic [FRAME_BITS-1:0] out_frame;
  logic out_fill_needed;
  logic out_writeback;
  logic [IN_FILE_BITS-1:0] out_wb_file_id;
  logic [IN_PAGE_BITS-1:0] out_wb_page_no;
  logic out_last;

  int fail_count;
  int pending_results;
  int writebacks_seen;
  int exceeded_seen;
  int items_sent;
  int quiet_cycles;
  logic idling;

  buffer_pool_clock_replacement #(.NUM_FRAMES(NUM_FRAMES)) dut (.*);

  bpcr_checker #(.NUM_FRAMES(NUM_FRAMES)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random back-pressure on the result channel.
  always @(negedge clk) begin
    out_stall <= idling && ($urandom_range(99) < 32);
  end

  // Ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("buffer_pool_clock_replacement: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drives one item, called and returning at a falling edge.
  task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [IN_FILE_BITS-1:0] f,
                           logic [IN_PAGE_BITS-1:0] p, logic md);
    while (idling && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_file_id    <= f;
    in_page_no    <= p;
    in_mark_dirty <= md;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Random item drawn mostly from a small working set so pages collide.
  task automatic send_random_item();
    int pick;
    logic [CMD_BITS-1:0] cmd;
    logic [IN_FILE_BITS-1:0] f;
    logic [IN_PAGE_BITS-1:0] p;
    pick = $urandom_range(99);
    if (pick < 36) cmd = CMD_REQUEST;
    else if (pick < 68) cmd = CMD_UNPIN;
    else if (pick < 80) cmd = CMD_ALLOCATE;
    else if (pick < 89) cmd = CMD_DISPOSE;
    else if (pick < 97) cmd = CMD_FLUSH;
    else cmd = 3'($urandom_range(7, 5));
    if ($urandom_range(19) == 0) begin
      f = 8'($urandom);
      p = 20'($urandom);
    end else begin
      f = 8'($urandom_range(3));
      p = 20'($urandom_range(5));
    end
    send_item(cmd, f, p, 1'($urandom));
  endtask

  initial begin
    in_valid      = 1'b0;
    in_command    = CMD_REQUEST;
    in_file_id    = '0;
    in_page_no    = '0;
    in_mark_dirty = 1'b0;
    out_stall     = 1'b0;
    idling        = 1'b1;
    items_sent    = 0;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: miss, hit, unpin cases, extremes, duplicate tags, dispose, flush.
    send_item(CMD_REQUEST, 8'd0, 20'd0, 1'b0);
    send_item(CMD_REQUEST, 8'd0, 20'd0, 1'b0);
    send_item(CMD_UNPIN, 8'd0, 20'd0, 1'b1);
    send_item(CMD_UNPIN, 8'd0, 20'd0, 1'b0);
    send_item(CMD_UNPIN, 8'd0, 20'd0, 1'b0);
    send_item(CMD_UNPIN, 8'd9, 20'd9, 1'b0);
    send_item(CMD_ALLOCATE, 8'hFF, 20'hFFFFF, 1'b0);
    send_item(CMD_ALLOCATE, 8'hFF, 20'hFFFFF, 1'b0);
    send_item(CMD_REQUEST, 8'hFF, 20'hFFFFF, 1'b0);
    send_item(3'd5, 8'hFF, 20'hFFFFF, 1'b1);
    send_item(3'd7, 8'h00, 20'h00000, 1'b1);
    send_item(CMD_DISPOSE, 8'd1, 20'd1, 1'b0);
    send_item(CMD_DISPOSE, 8'hFF, 20'hFFFFF, 1'b0);
    send_item(CMD_FLUSH, 8'hFF, 20'd0, 1'b0);
    send_item(CMD_FLUSH, 8'd0, 20'd0, 1'b0);

    // Pin every frame, overflow, then release all dirty and flush the file.
    send_item(CMD_DISPOSE, 8'hFF, 20'hFFFFF, 1'b0);
    for (int i = 0; i < NUM_FRAMES; i++) send_item(CMD_ALLOCATE, 8'd7, 20'(i), 1'b0);
    send_item(CMD_REQUEST, 8'd8, 20'd0, 1'b0);
    for (int i = 0; i < NUM_FRAMES; i++) send_item(CMD_UNPIN, 8'd7, 20'(i), 1'b1);
    send_item(CMD_FLUSH, 8'd7, 20'd0, 1'b0);

    // Pin count saturation on one page.
    for (int i = 0; i < 258; i++) send_item(CMD_REQUEST, 8'h5A, 20'hA5A5A, 1'b0);
    send_item(CMD_DISPOSE, 8'h5A, 20'hA5A5A, 1'b0);

    // Random part, with a stretch of no idling and one full drain pause.
    for (int n = 0; n < 120; n++) begin
      idling = !(n >= 40 && n < 80);
      if (n == 90) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0) @(negedge clk);
      end
      send_random_item();
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d items; saw %0d write-backs and %0d full-pool results",
             items_sent, writebacks_seen, exceeded_seen);
    if (fail_count == 0) begin
      $display("buffer_pool_clock_replacement: match");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("buffer_pool_clock_replacement: mismatch");
    end
    $finish;
  end

endmodule
